// File: src/tct_pkg.sv
// Shared types and codes for the touch contact table.
// No dependencies; used by tct_ctrl, tct_datapath and the top level.
package tct_pkg;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_UPDATE = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic list_step;
    } tct_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic list_go;
        logic more;
    } tct_stat_t;

endpackage

// File: src/tct_ctrl.sv
// Sequencer for the touch contact table: accept, execute, walk the slots for list.
// Depends on tct_pkg.
module tct_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tct_pkg::tct_stat_t  stat,
    output tct_pkg::tct_cmd_t   cmd,
    output logic                busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LIST = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = stat.list_go ? ST_LIST : ST_IDLE;
            end
            ST_LIST:
            begin
                // stop after the last active slot
                state_next = stat.more ? ST_LIST : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cmd.load      = start && (state_reg == ST_IDLE);
    assign cmd.exec      = (state_reg == ST_EXEC);
    assign cmd.list_step = (state_reg == ST_LIST);

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_list_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.list_step |-> $past(state_reg) == ST_EXEC || $past(state_reg) == ST_LIST)
        else $error("list walk entered without execute");
`endif

endmodule

// File: src/tct_datapath.sv
// Slot storage, id search, free-slot search and result registers of the contact table.
// Depends on tct_pkg; driven by tct_ctrl.
module tct_datapath #(
    parameter int SLOTS = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tct_pkg::tct_cmd_t   cmd,
    output tct_pkg::tct_stat_t  stat,
    input  logic [2:0]          operation,
    input  logic [7:0]          touch_id,
    input  logic [11:0]         pos_x,
    input  logic [11:0]         pos_y,
    input  logic [7:0]          press_level,
    input  logic [7:0]          contact_size,
    output logic                strobe,
    output logic [2:0]          slot_index,
    output logic [7:0]          out_id,
    output logic [11:0]         out_x,
    output logic [11:0]         out_y,
    output logic [7:0]          out_pressure,
    output logic [7:0]          out_size,
    output logic                entry_valid,
    output logic                matched,
    output logic [2:0]          active_count,
    output logic                last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // latched input beat
    logic [2:0]  op_reg;
    logic [7:0]  tid_reg;
    logic [11:0] x_in_reg;
    logic [11:0] y_in_reg;
    logic [7:0]  p_in_reg;
    logic [7:0]  s_in_reg;

    // slot table
    logic [SLOTS-1:0] active_reg;
    logic [7:0]       id_arr_reg [SLOTS];
    logic [11:0]      x_arr_reg  [SLOTS];
    logic [11:0]      y_arr_reg  [SLOTS];
    logic [7:0]       p_arr_reg  [SLOTS];
    logic [7:0]       s_arr_reg  [SLOTS];
    logic [7:0]       next_id_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] list_idx_reg;

    // search results
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    logic             more;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wslot;

    logic is_add, is_upd, is_rem, is_clr, is_list;
    logic do_add, do_wr, rem_hit;

    // result registers
    logic             strobe_reg,  strobe_next;
    logic [IDX_W-1:0] slot_reg,    slot_next;
    logic [7:0]       id_out_reg,  id_out_next;
    logic [11:0]      x_out_reg,   x_out_next;
    logic [11:0]      y_out_reg,   y_out_next;
    logic [7:0]       p_out_reg,   p_out_next;
    logic [7:0]       s_out_reg,   s_out_next;
    logic             ev_reg,      ev_next;
    logic             m_reg,       m_next;
    logic [CNT_W-1:0] cnt_out_reg;
    logic             last_reg,    last_next;

    logic [IDX_W+2:0] slot_ext;
    logic [CNT_W+2:0] cnt_ext;

    assign is_add  = (op_reg == tct_pkg::OP_ADD);
    assign is_upd  = (op_reg == tct_pkg::OP_UPDATE);
    assign is_rem  = (op_reg == tct_pkg::OP_REMOVE);
    assign is_clr  = (op_reg == tct_pkg::OP_CLEAR);
    assign is_list = (op_reg == tct_pkg::OP_LIST);

    // first active match, lowest free slot, any active slot beyond the list pointer
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        more     = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (active_reg[i] && (id_arr_reg[i] == tid_reg))
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!active_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (active_reg[i] && (IDX_W'(i) > list_idx_reg))
            begin
                more = 1'b1;
            end
        end
    end

    assign do_add  = is_add || (is_upd && !hit);
    assign do_wr   = do_add || (is_upd && hit);
    assign rem_hit = is_rem && hit;
    assign wslot   = do_add ? free_idx : hit_idx;
    assign rd_idx  = cmd.list_step ? list_idx_reg : hit_idx;

    assign stat.list_go = cmd.exec && is_list && (|active_reg);
    assign stat.more    = more;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.exec)
        begin
            if (do_add && !active_reg[free_idx])
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            else if (rem_hit)
            begin
                cnt_next = cnt_reg - 1'b1;
            end
            else if (is_clr)
            begin
                cnt_next = '0;
            end
        end
    end

    always_comb
    begin
        strobe_next = 1'b0;
        slot_next   = '0;
        id_out_next = '0;
        x_out_next  = '0;
        y_out_next  = '0;
        p_out_next  = '0;
        s_out_next  = '0;
        ev_next     = 1'b0;
        m_next      = 1'b0;
        last_next   = 1'b1;
        if (cmd.exec)
        begin
            // list with entries emits from the walk instead
            strobe_next = !is_list || !(|active_reg);
            if (do_wr)
            begin
                ev_next     = 1'b1;
                m_next      = !do_add;
                slot_next   = wslot;
                id_out_next = do_add ? next_id_reg : id_arr_reg[rd_idx];
                x_out_next  = x_in_reg;
                y_out_next  = y_in_reg;
                p_out_next  = p_in_reg;
                s_out_next  = s_in_reg;
            end
            else if (rem_hit)
            begin
                ev_next     = 1'b1;
                m_next      = 1'b1;
                slot_next   = hit_idx;
                id_out_next = id_arr_reg[rd_idx];
                x_out_next  = x_arr_reg[rd_idx];
                y_out_next  = y_arr_reg[rd_idx];
                s_out_next  = s_arr_reg[rd_idx];
            end
        end
        else if (cmd.list_step)
        begin
            strobe_next = active_reg[list_idx_reg];
            ev_next     = 1'b1;
            slot_next   = list_idx_reg;
            id_out_next = id_arr_reg[rd_idx];
            x_out_next  = x_arr_reg[rd_idx];
            y_out_next  = y_arr_reg[rd_idx];
            p_out_next  = p_arr_reg[rd_idx];
            s_out_next  = s_arr_reg[rd_idx];
            last_next   = !more;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            next_id_reg  <= '0;
            cnt_reg      <= '0;
            list_idx_reg <= '0;
            strobe_reg   <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                id_arr_reg[i] <= '0;
            end
        end
        else
        begin
            strobe_reg <= strobe_next;
            cnt_reg    <= cnt_next;
            if (cmd.exec)
            begin
                list_idx_reg <= '0;
                if (do_add)
                begin
                    active_reg[wslot] <= 1'b1;
                    id_arr_reg[wslot] <= next_id_reg;
                    next_id_reg       <= next_id_reg + 1'b1;
                end
                else if (rem_hit)
                begin
                    active_reg[hit_idx] <= 1'b0;
                end
                else if (is_clr)
                begin
                    active_reg <= '0;
                end
            end
            else if (cmd.list_step)
            begin
                list_idx_reg <= list_idx_reg + 1'b1;
            end
        end
    end

    // payload: beat latch, slot data and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            tid_reg  <= touch_id;
            x_in_reg <= pos_x;
            y_in_reg <= pos_y;
            p_in_reg <= press_level;
            s_in_reg <= contact_size;
        end
        if (cmd.exec && do_wr)
        begin
            x_arr_reg[wslot] <= x_in_reg;
            y_arr_reg[wslot] <= y_in_reg;
            p_arr_reg[wslot] <= p_in_reg;
            s_arr_reg[wslot] <= s_in_reg;
        end
        if (strobe_next)
        begin
            slot_reg    <= slot_next;
            id_out_reg  <= id_out_next;
            x_out_reg   <= x_out_next;
            y_out_reg   <= y_out_next;
            p_out_reg   <= p_out_next;
            s_out_reg   <= s_out_next;
            ev_reg      <= ev_next;
            m_reg       <= m_next;
            cnt_out_reg <= cnt_next;
            last_reg    <= last_next;
        end
    end

    assign slot_ext = {3'b000, slot_reg};
    assign cnt_ext  = {3'b000, cnt_out_reg};

    assign strobe       = strobe_reg;
    assign slot_index   = slot_ext[2:0];
    assign out_id       = id_out_reg;
    assign out_x        = x_out_reg;
    assign out_y        = y_out_reg;
    assign out_pressure = p_out_reg;
    assign out_size     = s_out_reg;
    assign entry_valid  = ev_reg;
    assign matched      = m_reg;
    assign active_count = cnt_ext[2:0];
    assign last         = last_reg;

`ifndef ASSERT_OFF
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(active_reg) == int'(cnt_reg))
        else $error("active count out of step with slot marks");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !entry_valid |-> last && (out_id == 8'd0) && !matched)
        else $error("empty result not final or carries data");
`endif

endmodule

// File: src/touch_contact_table_top.sv
// Touch contact table. Sequence: an accepted beat is latched, the execute state computes the
// result and the result registers drive the beat; add, update, remove, clear, unused codes and
// an empty list emit one beat each. A list with entries walks the slots up to the highest active
// one, one slot read per cycle, and emits one beat per active slot. Reset (rst_n, asynchronous)
// clears all slot marks, ids, the id counter and the count. The receiver cannot stall:
// each beat lasts one cycle.
module touch_contact_table_top #(
    parameter int SLOTS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [7:0]  touch_id,
    input  logic [11:0] pos_x,
    input  logic [11:0] pos_y,
    input  logic [7:0]  press_level,
    input  logic [7:0]  contact_size,
    output logic        strobe,
    output logic [2:0]  slot_index,
    output logic [7:0]  out_id,
    output logic [11:0] out_x,
    output logic [11:0] out_y,
    output logic [7:0]  out_pressure,
    output logic [7:0]  out_size,
    output logic        entry_valid,
    output logic        matched,
    output logic [2:0]  active_count,
    output logic        last
);

    tct_pkg::tct_cmd_t  cmd;
    tct_pkg::tct_stat_t stat;

    tct_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tct_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (operation),
        .touch_id     (touch_id),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .press_level  (press_level),
        .contact_size (contact_size),
        .strobe       (strobe),
        .slot_index   (slot_index),
        .out_id       (out_id),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_pressure (out_pressure),
        .out_size     (out_size),
        .entry_valid  (entry_valid),
        .matched      (matched),
        .active_count (active_count),
        .last         (last)
    );

`ifndef ASSERT_OFF
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("non-final beat with the block idle");
`endif

endmodule
